// ----- rtl/rkf_pkg.sv -----
// ----------------------------------------------------------------------------
// rkf_pkg
// Shared constants and the reciprocal table for the k-factor pipeline.
// ----------------------------------------------------------------------------
package rkf_pkg;

  localparam logic [15:0] T_LOW      = 16'd100;
  localparam logic [15:0] T_DFLT     = 16'd28815;
  localparam logic [15:0] T_ZERO_C   = 16'd27315;
  localparam logic [15:0] T_POLE     = 16'd3218;
  localparam logic [19:0] P_DFLT     = 20'd101325;
  localparam logic [16:0] H_ONE      = 17'd65536;

  localparam int DIV_NW = 60;
  localparam int DIV_DW = 32;
  localparam int DIV_QW = 42;

  localparam logic [29:0] MAG_NUM_K  = 30'd17502;
  localparam logic [25:0] MAG_DEN_K  = 26'd1000;
  localparam logic [29:0] DRY_K      = 30'd776;

  localparam logic [59:0] VAP_NUM     = 60'(64'd22798133000 << 20);
  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [36:0] LN2_X64     = 37'(64'd744261118 * 64'd64);
  // floor(2^50 / LN2_Q30), applied to the argument shifted right by 10
  localparam logic [20:0] LN2_RCP     = 21'((64'd1 << 50) / 64'd744261118);
  localparam logic [41:0] ARG_NEG_MAX = 42'(64'd32 << 30);
  localparam logic [41:0] ARG_POS_MAX = 42'(64'd24 << 30);
  localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
  localparam logic [36:0] N_CAP       = 37'(64'd1 << 36);
  localparam logic [40:0] X_CAP       = 41'(64'd1 << 40);
  localparam logic [32:0] K_SCALE     = 33'(64'd115395 << 16);
  localparam logic [17:0] OUT_MAX     = 18'h3FFFF;

  localparam int HORNER_TERMS = 12;

  // floor(2^33 / i)
  function automatic logic [33:0] horner_recip(input logic [3:0] i);
    logic [33:0] m;
    case (i)
      4'd1:    m = 34'd8589934592;
      4'd2:    m = 34'd4294967296;
      4'd3:    m = 34'd2863311530;
      4'd4:    m = 34'd2147483648;
      4'd5:    m = 34'd1717986918;
      4'd6:    m = 34'd1431655765;
      4'd7:    m = 34'd1227133513;
      4'd8:    m = 34'd1073741824;
      4'd9:    m = 34'd954437176;
      4'd10:   m = 34'd858993459;
      4'd11:   m = 34'd780903144;
      4'd12:   m = 34'd715827882;
      default: m = 34'd0;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/rkf_div.sv -----
// ----------------------------------------------------------------------------
// rkf_div
// Pipelined restoring divider, QW+1 stages: an input stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module rkf_div #(
  parameter int NW = 60,
  parameter int DW = 32,
  parameter int QW = 42
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic          ovf
);

  logic [DW-1:0] rem_r [QW+1];
  logic [QW-1:0] lq_r  [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic          ovf_r [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(num >> QW);
      lq_r[0]  <= num[QW-1:0];
      den_r[0] <= den;
      ovf_r[0] <= (num >> QW) >= NW'(den);
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem_r[j-1], lq_r[j-1][QW-1]};
    assign ge    = trial >= {1'b0, den_r[j-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? DW'(trial - {1'b0, den_r[j-1]}) : DW'(trial);
        lq_r[j]  <= {lq_r[j-1][QW-2:0], ge};
        den_r[j] <= den_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  assign quo = lq_r[QW];
  assign rem = rem_r[QW];
  assign ovf = ovf_r[QW];

endmodule

// ----- rtl/refractivity_k_factor.sv -----
// ----------------------------------------------------------------------------
// refractivity_k_factor
// Effective earth radius k-factor from temperature, pressure and humidity.
// ----------------------------------------------------------------------------
// One atmospheric sample per item on the in_ channel (valid/ready), one
// k-factor item per sample on the out_ channel (valid/ready).
// The block is a fixed pipeline of 96 + OUT_FRAC_BITS register stages:
// a 43-stage divider for the Magnus argument, vapor factor and dry term,
// a 3-stage range reduction by ln2 (reciprocal multiply, one correction),
// a 12-term Horner exp at 3 stages per term, the wet/dry refractivity sum
// and a final (OUT_FRAC_BITS+3)-stage divider for k.
// Throughput is one item per cycle while out_ready does not stall the pipeline.
// Reset clears the valid bits only; data registers are not reset.
// When out_valid is high and out_ready low, the whole pipeline holds and
// in_ready drops; otherwise it advances every cycle, bubbles included.
// No item is lost or repeated across a stall.
// out_used_default flags the 4/3 fallback.
// ----------------------------------------------------------------------------
module refractivity_k_factor
  import rkf_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [15:0] in_temperature_ck,
  input  logic        [19:0] in_pressure_chpa,
  input  logic signed [17:0] in_humidity_q16,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [17:0] out_k_factor_q16,
  output logic               out_used_default
);

  localparam int DA_LAT = DIV_QW + 1;
  localparam int LN_QW  = 7;
  localparam int LN_LAT = 3;
  localparam int HN_LAT = 3 * HORNER_TERMS;
  localparam int KQW    = OUT_FRAC_BITS + 2;
  localparam int KNW    = OUT_FRAC_BITS + 34;
  localparam int DK_LAT = KQW + 1;
  localparam int LAT    = 2 + DA_LAT + 1 + LN_LAT + HN_LAT + 7 + DK_LAT + 1;

  localparam logic [63:0] KFB_RAW = ((64'd4 << OUT_FRAC_BITS) + 64'd1) / 64'd3;
  localparam logic [17:0] KFB     = (KFB_RAW > 64'(OUT_MAX)) ? OUT_MAX : KFB_RAW[17:0];

  logic           en;
  logic [LAT-1:0] vld_r;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // input cleanup
  logic [15:0] t0_r;
  logic [19:0] p0_r;
  logic [16:0] h0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r <= (in_temperature_ck <= T_LOW) ? T_DFLT : in_temperature_ck;
      p0_r <= (in_pressure_chpa == 20'd0) ? P_DFLT : in_pressure_chpa;
      if (in_humidity_q16[17]) begin
        h0_r <= 17'd0;
      end else begin
        h0_r <= (in_humidity_q16[16:0] > H_ONE) ? H_ONE : in_humidity_q16[16:0];
      end
    end
  end

  // dividend/divisor forming
  logic        num_neg, den_neg;
  logic [15:0] num_abs, den_abs;
  logic [59:0] an_r, dn_r;
  logic [31:0] ad_r, tt_r, dd_r;
  logic [16:0] h1_r;
  logic        sg1_r, dz1_r;

  assign num_neg = t0_r < T_ZERO_C;
  assign num_abs = num_neg ? (T_ZERO_C - t0_r) : (t0_r - T_ZERO_C);
  assign den_neg = t0_r < T_POLE;
  assign den_abs = den_neg ? (T_POLE - t0_r) : (t0_r - T_POLE);

  always_ff @(posedge clk) begin
    if (en) begin
      an_r  <= {30'(num_abs) * MAG_NUM_K, 30'd0};
      ad_r  <= 32'(26'(den_abs) * MAG_DEN_K);
      sg1_r <= num_neg ^ den_neg;
      dz1_r <= den_abs == 16'd0;
      tt_r  <= 32'(t0_r) * 32'(t0_r);
      dn_r  <= {6'd0, 30'(p0_r) * DRY_K, 24'd0};
      dd_r  <= 32'(t0_r) * 32'd10;
      h1_r  <= h0_r;
    end
  end

  logic [DIV_QW-1:0] q_arg, q_kf, q_dry;
  logic              o_arg, o_dry;

  rkf_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_arg (
    .clk(clk), .en(en), .num(an_r), .den(ad_r),
    .quo(q_arg), .rem(), .ovf(o_arg)
  );

  rkf_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_kf (
    .clk(clk), .en(en), .num(VAP_NUM), .den(tt_r),
    .quo(q_kf), .rem(), .ovf()
  );

  rkf_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_dry (
    .clk(clk), .en(en), .num(dn_r), .den(dd_r),
    .quo(q_dry), .rem(), .ovf(o_dry)
  );

  logic [18:0] sa_r [DA_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r[0] <= {h1_r, sg1_r, dz1_r};
      for (int i = 1; i < DA_LAT; i++) sa_r[i] <= sa_r[i-1];
    end
  end

  // exponent argument offset by 64*ln2, dry term cap
  logic [16:0] h2;
  logic        sg2, dz2;
  logic [41:0] mag_neg, mag_pos;
  logic [36:0] a2, dry2;
  logic [36:0] a2_r;
  logic [95:0] s2_r;

  assign {h2, sg2, dz2} = sa_r[DA_LAT-1];
  assign mag_neg = (o_arg || q_arg > ARG_NEG_MAX) ? ARG_NEG_MAX : q_arg;
  assign mag_pos = (o_arg || q_arg > ARG_POS_MAX) ? ARG_POS_MAX : q_arg;

  always_comb begin
    if (dz2) begin
      a2 = LN2_X64 + 37'(ARG_POS_MAX);
    end else if (sg2) begin
      a2 = LN2_X64 - 37'(mag_neg);
    end else begin
      a2 = LN2_X64 + 37'(mag_pos);
    end
  end

  assign dry2 = (o_dry || q_dry > 42'(N_CAP)) ? N_CAP : 37'(q_dry);

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r <= a2;
      s2_r <= {h2, q_kf, dry2};
    end
  end

  // range reduction by ln2: quotient estimate, remainder, one correction
  logic [47:0]      lp_r;
  logic [36:0]      la_r;
  logic [LN_QW-1:0] lq0;
  logic [36:0]      lqm;
  logic [30:0]      lrem;
  logic [LN_QW-1:0] lq_r;
  logic [30:0]      lrm_r;
  logic             lfix;
  logic [LN_QW-1:0] lnq_r;
  logic [29:0]      lnr_r;
  logic [LN_QW-1:0] ln_q;
  logic [29:0]      ln_r;

  assign lq0  = lp_r[46:40];
  assign lqm  = 37'(lq0) * 37'(LN2_Q30);
  assign lrem = 31'(la_r - lqm);
  assign lfix = lrm_r >= 31'(LN2_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      lp_r  <= 48'(a2_r[36:10]) * 48'(LN2_RCP);
      la_r  <= a2_r;
      lq_r  <= lq0;
      lrm_r <= lrem;
      lnq_r <= lq_r + LN_QW'(lfix);
      lnr_r <= lfix ? 30'(lrm_r - 31'(LN2_Q30)) : lrm_r[29:0];
    end
  end

  assign ln_q = lnq_r;
  assign ln_r = lnr_r;

  logic [95:0] sl_r [LN_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sl_r[0] <= s2_r;
      for (int i = 1; i < LN_LAT; i++) sl_r[i] <= sl_r[i-1];
    end
  end

  // exp(r) by Horner, three stages per term
  logic [102:0] hs_r [HN_LAT];
  logic [31:0]  hv_r [HORNER_TERMS];
  logic [31:0]  hq_r [HORNER_TERMS];
  logic [31:0]  hw_r [HORNER_TERMS];
  logic [31:0]  hp_r [HORNER_TERMS];
  logic [29:0]  ra_r [HORNER_TERMS];
  logic [29:0]  rb_r [HORNER_TERMS];
  logic [29:0]  rc_r [HORNER_TERMS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      hs_r[0] <= {sl_r[LN_LAT-1][95:79], ln_q, sl_r[LN_LAT-1][78:0]};
      for (int i = 1; i < HN_LAT; i++) hs_r[i] <= hs_r[i-1];
    end
  end

  for (genvar j = 0; j < HORNER_TERMS; j++) begin : g_horner
    localparam logic [3:0]  DIVI = 4'(HORNER_TERMS - j);
    localparam logic [33:0] RCP  = horner_recip(DIVI);
    logic [31:0] pin;
    logic [29:0] rin;
    logic [61:0] prod;
    logic [65:0] qm;
    logic [35:0] qi, rm;
    logic        fix;

    if (j == 0) begin : g_first
      assign pin = Q30_ONE;
      assign rin = ln_r;
    end else begin : g_next
      assign pin = hp_r[j-1];
      assign rin = rc_r[j-1];
    end

    assign prod = 62'(pin) * 62'(rin);
    assign qm   = 66'(hv_r[j]) * 66'(RCP);
    assign qi   = 36'(hq_r[j]) * 36'(DIVI);
    assign rm   = 36'(hw_r[j]) - qi;
    assign fix  = rm >= 36'(DIVI);

    always_ff @(posedge clk) begin
      if (en) begin
        hv_r[j] <= prod[61:30];
        ra_r[j] <= rin;
        hq_r[j] <= qm[64:33];
        hw_r[j] <= hv_r[j];
        rb_r[j] <= ra_r[j];
        hp_r[j] <= Q30_ONE + hq_r[j] + 32'(fix);
      end
    end

    if (j < HORNER_TERMS - 1) begin : g_rpass
      always_ff @(posedge clk) begin
        if (en) rc_r[j] <= rb_r[j];
      end
    end
  end

  // humidity times exp
  logic [16:0]      hh;
  logic [LN_QW-1:0] nq_h;
  logic [41:0]      kf_h;
  logic [36:0]      dry_h;
  logic [47:0]      m_r;
  logic [LN_QW-1:0] nq_m_r;
  logic [78:0]      sm_r;

  assign {hh, nq_h, kf_h, dry_h} = hs_r[HN_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= 48'(hh) * 48'(hp_r[HORNER_TERMS-1]);
      nq_m_r <= nq_h;
      sm_r   <= {kf_h, dry_h};
    end
  end

  // scale by 2^(n-16), clamp
  logic signed [8:0] sc;
  logic [95:0]       x_ext;
  logic [40:0]       xs_r;
  logic [78:0]       sx_r;

  assign sc = $signed({2'b00, nq_m_r}) - 9'sd80;

  always_comb begin
    if (sc >= 9'sd0) begin
      x_ext = {48'd0, m_r} << sc[5:0];
    end else begin
      x_ext = {48'd0, m_r} >> 7'(-sc);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs_r <= (x_ext > 96'(X_CAP)) ? X_CAP : x_ext[40:0];
      sx_r <= sm_r;
    end
  end

  // wet term partial products
  logic [41:0] kf_x;
  logic [41:0] pll_r, phl_r;
  logic [40:0] plh_r, phh_r;
  logic [36:0] dry_p_r;

  assign kf_x = sx_r[78:37];

  always_ff @(posedge clk) begin
    if (en) begin
      pll_r   <= 42'(kf_x[20:0]) * 42'(xs_r[20:0]);
      plh_r   <= 41'(kf_x[20:0]) * 41'(xs_r[40:21]);
      phl_r   <= 42'(kf_x[41:21]) * 42'(xs_r[20:0]);
      phh_r   <= 41'(kf_x[41:21]) * 41'(xs_r[40:21]);
      dry_p_r <= sx_r[36:0];
    end
  end

  logic [83:0] wsum;
  logic [36:0] wet_r, dry_w_r;

  assign wsum = 84'(pll_r) + ((84'(plh_r) + 84'(phl_r)) << 21) + (84'(phh_r) << 42);

  always_ff @(posedge clk) begin
    if (en) begin
      wet_r   <= ((wsum >> 26) > 84'(N_CAP)) ? N_CAP : 37'(wsum >> 26);
      dry_w_r <= dry_p_r;
    end
  end

  // refractivity and its scaled form
  logic [37:0] nsum;
  logic [36:0] ncap;
  logic [35:0] nn_r;

  assign nsum = 38'(dry_w_r) + 38'(wet_r);
  assign ncap = (nsum > 38'(N_CAP)) ? N_CAP : nsum[36:0];

  always_ff @(posedge clk) begin
    if (en) nn_r <= 36'(ncap[36:8]) * 36'd100;
  end

  // denominator and range checks
  logic        n_over;
  logic [32:0] dd;
  logic [36:0] d37, k37;
  logic        fb_d;
  logic [32:0] d_r;
  logic        fb_r;

  assign n_over = nn_r >= 36'(K_SCALE);
  assign dd     = 33'(36'(K_SCALE) - nn_r);
  assign d37    = 37'(dd);
  assign k37    = 37'(K_SCALE);
  assign fb_d   = n_over || (d37 * 37'd10 <= k37) || ((k37 << 1) > d37 * 37'd5) ||
                  ((k37 << 1) < d37);

  always_ff @(posedge clk) begin
    if (en) begin
      d_r  <= dd;
      fb_r <= fb_d;
    end
  end

  // rounded dividend for k
  logic [KNW-1:0] kn_r;
  logic [32:0]    kd_r;
  logic           fb_e_r;

  always_ff @(posedge clk) begin
    if (en) begin
      kn_r   <= (KNW'(K_SCALE) << OUT_FRAC_BITS) + KNW'(d_r >> 1);
      kd_r   <= d_r;
      fb_e_r <= fb_r;
    end
  end

  logic [KQW-1:0] kq;

  rkf_div #(.NW(KNW), .DW(33), .QW(KQW)) u_div_k (
    .clk(clk), .en(en), .num(kn_r), .den(kd_r),
    .quo(kq), .rem(), .ovf()
  );

  logic fbd_r [DK_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      fbd_r[0] <= fb_e_r;
      for (int i = 1; i < DK_LAT; i++) fbd_r[i] <= fbd_r[i-1];
    end
  end

  // output register
  logic [17:0] k_out_r;
  logic        fb_out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (fbd_r[DK_LAT-1]) begin
        k_out_r <= KFB;
      end else begin
        k_out_r <= (64'(kq) > 64'(OUT_MAX)) ? OUT_MAX : 18'(kq);
      end
      fb_out_r <= fbd_r[DK_LAT-1];
    end
  end

  assign out_k_factor_q16 = k_out_r;
  assign out_used_default = fb_out_r;

endmodule

// ----- sim/rkf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkf_checker
// Watches both channels of refractivity_k_factor, predicts the k-factor of
// every accepted sample and compares each accepted result with it, in order.
// ----------------------------------------------------------------------------
module rkf_checker #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic        [15:0] in_temperature_ck,
  input  logic        [19:0] in_pressure_chpa,
  input  logic signed [17:0] in_humidity_q16,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic        [17:0] out_k_factor_q16,
  input  logic               out_used_default,
  output int                 fail_count,
  output int                 pending_count
);

  localparam logic [63:0] LN2 = 64'd744261118;
  localparam logic [63:0] Q30 = 64'd1 << 30;
  localparam logic [63:0] N_SAT = 64'd4096 << 24;
  localparam logic [63:0] KSC = 64'd115395 << 16;

  typedef struct packed {
    logic [17:0] k;
    logic        fb;
  } k_result_t;

  k_result_t k_expected_q[$];

  function automatic k_result_t predict_k(logic [15:0] t_in, logic [19:0] p_in,
                                          logic [17:0] h_in);
    logic [63:0] t, p, h, nm, dm, q, a, r, pe, m, x, kf, wet, dry, nq, nn, d, k;
    logic        nneg, dneg, fb;
    longint      arg;
    int          n, s;
    k_result_t   res;
    t = (t_in <= 100) ? 64'd28815 : 64'(t_in);
    p = (p_in == 0) ? 64'd101325 : 64'(p_in);
    if (h_in[17]) h = 0;
    else h = (h_in > 65536) ? 64'd65536 : 64'(h_in);
    nneg = t < 27315;
    nm = 17502 * (nneg ? 27315 - t : t - 27315);
    dneg = t < 3218;
    dm = 1000 * (dneg ? 3218 - t : t - 3218);
    if (dm == 0) arg = longint'(64'd24 << 30);
    else begin
      q = (nm << 30) / dm;
      if (nneg != dneg) arg = -longint'((q > (64'd32 << 30)) ? (64'd32 << 30) : q);
      else arg = longint'((q > (64'd24 << 30)) ? (64'd24 << 30) : q);
    end
    a = 64'(arg + longint'(64 * LN2));
    n = int'(a / LN2) - 64;
    r = a % LN2;
    pe = Q30;
    for (int i = 12; i >= 1; i--) pe = Q30 + ((pe * r) >> 30) / i;
    m = h * pe;
    s = n - 16;
    if (s >= 0) x = (m > ({64{1'b1}} >> s)) ? {64{1'b1}} : (m << s);
    else x = (-s >= 64) ? 64'd0 : (m >> (-s));
    kf = (64'd22798133000 << 20) / (t * t);
    if (x != 0 && kf > {64{1'b1}} / x) wet = N_SAT;
    else begin
      wet = (kf * x) >> 26;
      if (wet > N_SAT) wet = N_SAT;
    end
    dry = ((776 * p) << 24) / (10 * t);
    if (dry > N_SAT) dry = N_SAT;
    nq = dry + wet;
    if (nq > N_SAT) nq = N_SAT;
    nn = (nq >> 8) * 100;
    k = 0;
    fb = 0;
    if (nn >= KSC) fb = 1;
    else begin
      d = KSC - nn;
      if (10 * d <= KSC) fb = 1;
      else if (2 * KSC > 5 * d) fb = 1;
      else if (2 * KSC < d) fb = 1;
      else k = ((KSC << OUT_FRAC_BITS) + d / 2) / d;
    end
    if (fb) k = ((64'd4 << OUT_FRAC_BITS) + 1) / 3;
    if (k > 64'h3FFFF) k = 64'h3FFFF;
    res.k = k[17:0];
    res.fb = fb;
    return res;
  endfunction

  always @(posedge clk) begin
    k_result_t exp_r;
    if (!rst_n) begin
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (in_valid && in_ready)
        k_expected_q.push_back(predict_k(in_temperature_ck, in_pressure_chpa,
                                         in_humidity_q16));
      if (out_valid && out_ready) begin
        if (k_expected_q.size() == 0) begin
          $display("%0t: unexpected result k=%0d flag=%0b", $time, out_k_factor_q16,
                   out_used_default);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = k_expected_q.pop_front();
          if (exp_r.k !== out_k_factor_q16 || exp_r.fb !== out_used_default) begin
            $display("%0t: mismatch k exp=%0d act=%0d, flag exp=%0b act=%0b", $time,
                     exp_r.k, out_k_factor_q16, exp_r.fb, out_used_default);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= k_expected_q.size();
    end
  end

endmodule

// ----- sim/tb_refractivity_k_factor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_refractivity_k_factor
// Drives directed and random atmospheric samples with random gaps and
// output stalls, including one long stall; the checker scores the results.
// ----------------------------------------------------------------------------
module tb_refractivity_k_factor;

  localparam int RAND_ITEMS = 1900;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 150;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic        [15:0] in_temperature_ck;
  logic        [19:0] in_pressure_chpa;
  logic signed [17:0] in_humidity_q16;
  logic               out_valid;
  logic               out_ready;
  logic        [17:0] out_k_factor_q16;
  logic               out_used_default;
  int                 fail_count;
  int                 pending_count;
  int                 idle_cycles;
  bit                 stim_done;
  bit                 long_stall_done;
  bit                 timed_out;

  refractivity_k_factor u_dut (.*);

  rkf_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_sample(logic [15:0] t, logic [19:0] p, logic [17:0] h);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_temperature_ck <= t;
    in_pressure_chpa <= p;
    in_humidity_q16 <= h;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    logic [15:0] t;
    logic [19:0] p;
    logic [17:0] h;
    rst_n = 0;
    in_valid = 0;
    in_temperature_ck = 0;
    in_pressure_chpa = 0;
    in_humidity_q16 = 0;
    stim_done = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_sample(16'd0, 20'd0, 18'd0);
    send_sample(16'd100, 20'd101325, 18'd65536);
    send_sample(16'd101, 20'd101325, 18'd32768);
    send_sample(16'd65535, 20'hFFFFF, 18'h1FFFF);
    send_sample(16'd3218, 20'd101325, 18'd65536);
    send_sample(16'd3218, 20'd101325, 18'd0);
    send_sample(16'd3217, 20'd50000, 18'd65536);
    send_sample(16'd3219, 20'd50000, 18'd65536);
    send_sample(16'd27315, 20'd101325, 18'd65536);
    send_sample(16'd28815, 20'd0, 18'h20000);
    send_sample(16'd28815, 20'd101325, 18'h3FFFF);
    send_sample(16'd28815, 20'd101325, 18'd65537);
    send_sample(16'd30315, 20'd101325, 18'd65536);
    send_sample(16'd31315, 20'd101325, 18'd65536);
    send_sample(16'd20000, 20'd30000, 18'd10000);
    send_sample(16'd1000, 20'hFFFFF, 18'd65536);
    send_sample(16'd65535, 20'd1, 18'd0);
    send_sample(16'd29000, 20'd80000, 18'd50000);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        t = 16'($urandom);
        p = 20'($urandom);
        h = 18'($urandom);
      end else begin
        t = 16'($urandom_range(22000, 32500));
        p = 20'($urandom_range(30000, 110000));
        h = 18'($urandom_range(0, 65536));
      end
      send_sample(t, p, h);
    end
    in_valid <= 0;
    @(posedge clk);
    stim_done = 1;
  end

  initial begin
    int gap;
    long_stall_done = 0;
    out_ready = 0;
    wait (rst_n);
    repeat (300) @(posedge clk);
    repeat (400) @(posedge clk);
    long_stall_done = 1;
    forever begin
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || !long_stall_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    timed_out = 0;
    wait (rst_n);
    fork
      begin
        wait (stim_done && pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        timed_out = 1;
      end
    join_any
    if (fail_count == 0 && !timed_out) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- refractivity_k_factor.f -----
rtl/rkf_pkg.sv
rtl/rkf_div.sv
rtl/refractivity_k_factor.sv
sim/rkf_checker.sv
sim/tb_refractivity_k_factor.sv
